/* rtl/led_animation_button_sequencer_top_defines.svh */
// ----------------------------------------------------------------------------
// led animation button sequencer assertion macros
// shared property wrappers, clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef LED_ANIMATION_BUTTON_SEQUENCER_TOP_DEFINES_SVH
`define LED_ANIMATION_BUTTON_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication
`define LAB_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LAB_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/lab_pkg.sv */
// ----------------------------------------------------------------------------
// lab_pkg
// types, constants and animation tables of the led animation sequencer
// ----------------------------------------------------------------------------
package lab_pkg;

   localparam int NUM_ANIMATIONS = 4;
   localparam int ROM_FRAMES     = 26;

   // input function codes
   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_WAKE = 1'b1;

   // csr indexes
   localparam logic [1:0] CSR_SHORT_PRESS = 2'd0;
   localparam logic [1:0] CSR_LONG_PRESS  = 2'd1;
   localparam logic [1:0] CSR_BRIGHT_STEP = 2'd2;

   localparam logic [7:0] SHORT_PRESS_RESET = 8'h05;
   localparam logic [7:0] LONG_PRESS_RESET  = 8'h30;
   localparam logic [7:0] BRIGHT_STEP_RESET = 8'h40;
   localparam logic [7:0] LEVEL_FULL        = 8'd255;

   typedef struct packed {
      logic [7:0] short_press_ticks;
      logic [7:0] long_press_ticks;
      logic [7:0] brightness_step;
   } cfg_type;

   typedef struct packed {
      logic [7:0] led_bits;
      logic       nose_on;
      logic [7:0] duty;
      logic       full_on;
      logic       sleeping;
   } result_type;

   typedef struct packed {
      logic [7:0] brightness;
      logic       dimming_enabled;
   } level_type;

   // apply a new brightness level
   function automatic level_type set_level(input logic [7:0] v, input logic [7:0] cur);
      level_type r;
      if (v == 8'd0) begin
         r.brightness      = 8'd0;
         r.dimming_enabled = 1'b0;
      end else if (v == LEVEL_FULL) begin
         r.brightness      = cur;
         r.dimming_enabled = 1'b0;
      end else begin
         r.brightness      = v;
         r.dimming_enabled = 1'b1;
      end
      return r;
   endfunction

   function automatic logic [4:0] anim_start(input logic [1:0] a);
      logic [4:0] r;
      case (a)
         2'd0:    r = 5'd0;
         2'd1:    r = 5'd2;
         2'd2:    r = 5'd6;
         2'd3:    r = 5'd25;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

   function automatic logic [4:0] anim_count(input logic [1:0] a);
      logic [4:0] r;
      case (a)
         2'd0:    r = 5'd2;
         2'd1:    r = 5'd4;
         2'd2:    r = 5'd19;
         2'd3:    r = 5'd1;
         default: r = 5'd1;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] anim_len(input logic [1:0] a);
      logic [7:0] r;
      case (a)
         2'd3:    r = 8'd255;
         default: r = 8'd24;
      endcase
      return r;
   endfunction

   // bit 8 nose, bits 7..0 led byte
   function automatic logic [8:0] rom_word(input logic [5:0] addr);
      logic [8:0] r;
      case (addr)
         6'd0:    r = 9'h0AA;
         6'd1:    r = 9'h155;
         6'd2:    r = 9'h000;
         6'd3:    r = 9'h100;
         6'd4:    r = 9'h1F0;
         6'd5:    r = 9'h1FF;
         6'd6:    r = 9'h000;
         6'd7:    r = 9'h000;
         6'd8:    r = 9'h080;
         6'd9:    r = 9'h0C0;
         6'd10:   r = 9'h0E0;
         6'd11:   r = 9'h0F0;
         6'd12:   r = 9'h0F8;
         6'd13:   r = 9'h0FC;
         6'd14:   r = 9'h0FE;
         6'd15:   r = 9'h0FF;
         6'd16:   r = 9'h1FF;
         6'd17:   r = 9'h000;
         6'd18:   r = 9'h000;
         6'd19:   r = 9'h1FF;
         6'd20:   r = 9'h1FF;
         6'd21:   r = 9'h000;
         6'd22:   r = 9'h000;
         6'd23:   r = 9'h1FF;
         6'd24:   r = 9'h1FF;
         6'd25:   r = 9'h1FF;
         default: r = 9'h000;
      endcase
      return r;
   endfunction

endpackage

/* rtl/lab_csr.sv */
// ----------------------------------------------------------------------------
// lab_csr
// configuration registers written through the csr port
// ----------------------------------------------------------------------------
module lab_csr
   import lab_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data,
   output cfg_type    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_SHORT_PRESS: cfg_in.short_press_ticks = csr_data;
            CSR_LONG_PRESS:  cfg_in.long_press_ticks  = csr_data;
            CSR_BRIGHT_STEP: cfg_in.brightness_step   = csr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_press_ticks <= SHORT_PRESS_RESET;
         cfg_ff.long_press_ticks  <= LONG_PRESS_RESET;
         cfg_ff.brightness_step   <= BRIGHT_STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/lab_core.sv */
// ----------------------------------------------------------------------------
// lab_core
// sequencer state and the per-item next state and result logic
// ----------------------------------------------------------------------------
module lab_core
   import lab_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       fire,
   input  logic       func,
   input  logic       button_pressed,
   output result_type result
);

   logic [2:0] phase_ff, phase_in;
   logic [7:0] press_ff, press_in;
   logic [7:0] prev_ff, prev_in;
   logic [1:0] sel_ff, sel_in;
   logic [4:0] fidx_ff, fidx_in;
   logic [7:0] ftimer_ff, ftimer_in;
   logic [7:0] bright_ff, bright_in;
   logic       dim_ff, dim_in;
   logic       asleep_ff, asleep_in;

   always_comb begin
      level_type  lvl;
      logic [5:0] addr;
      logic [8:0] entry;
      logic [2:0] sel_wide;

      phase_in  = phase_ff;
      press_in  = press_ff;
      prev_in   = prev_ff;
      sel_in    = sel_ff;
      fidx_in   = fidx_ff;
      ftimer_in = ftimer_ff;
      bright_in = bright_ff;
      dim_in    = dim_ff;
      asleep_in = asleep_ff;
      lvl       = '0;
      addr      = '0;
      entry     = '0;
      sel_wide  = '0;
      result.led_bits = 8'd0;
      result.nose_on  = 1'b0;

      if (func == FUNC_WAKE) begin
         if (asleep_ff && button_pressed) begin
            lvl       = set_level(cfg.brightness_step, bright_ff);
            bright_in = lvl.brightness;
            dim_in    = lvl.dimming_enabled;
            asleep_in = 1'b0;
         end
      end else if (!asleep_ff) begin
         phase_in = phase_ff + 3'd1;
         // button logic once per phase wrap
         if (phase_in == 3'd0) begin
            if (button_pressed) begin
               if (press_ff <= cfg.long_press_ticks) begin
                  press_in = press_ff + 8'd1;
               end
            end else begin
               press_in = 8'd0;
            end
            if (press_in == cfg.long_press_ticks) begin
               lvl       = set_level(bright_ff + cfg.brightness_step, bright_ff);
               bright_in = lvl.brightness;
               dim_in    = lvl.dimming_enabled;
            end else if (prev_ff > cfg.short_press_ticks &&
                         prev_ff < cfg.long_press_ticks && press_in == 8'd0) begin
               sel_wide = {1'b0, sel_ff} + 3'd1;
               if (sel_wide >= 3'(NUM_ANIMATIONS)) begin
                  sel_in = 2'd0;
               end else begin
                  sel_in = sel_wide[1:0];
               end
               fidx_in   = 5'd0;
               ftimer_in = 8'd0;
            end else begin
               ftimer_in = ftimer_ff + 8'd1;
               if (ftimer_in >= anim_len(sel_ff)) begin
                  ftimer_in = 8'd0;
                  fidx_in   = fidx_ff + 5'd1;
                  if (fidx_in >= anim_count(sel_ff)) begin
                     fidx_in = 5'd0;
                  end
               end
            end
            prev_in = press_in;
         end
         if (bright_in != 8'd0) begin
            addr = 6'(anim_start(sel_in)) + 6'(fidx_in);
            if (addr < 6'(ROM_FRAMES)) begin
               entry = rom_word(addr);
            end
            result.led_bits = entry[7:0] & (8'd1 << phase_in);
            result.nose_on  = entry[8] && (phase_in == 3'd0);
         end else begin
            // off: go to sleep
            fidx_in   = 5'd0;
            ftimer_in = 8'd0;
            phase_in  = 3'd0;
            asleep_in = 1'b1;
         end
      end

      result.duty     = asleep_in ? 8'd0 : bright_in;
      result.full_on  = !asleep_in && !dim_in;
      result.sleeping = asleep_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= 3'd0;
         press_ff  <= 8'd0;
         prev_ff   <= 8'd0;
         sel_ff    <= 2'd0;
         fidx_ff   <= 5'd0;
         ftimer_ff <= 8'd0;
         bright_ff <= BRIGHT_STEP_RESET;
         dim_ff    <= 1'b1;
         asleep_ff <= 1'b0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         press_ff  <= press_in;
         prev_ff   <= prev_in;
         sel_ff    <= sel_in;
         fidx_ff   <= fidx_in;
         ftimer_ff <= ftimer_in;
         bright_ff <= bright_in;
         dim_ff    <= dim_in;
         asleep_ff <= asleep_in;
      end
   end

endmodule

/* rtl/led_animation_button_sequencer_top.sv */
// ----------------------------------------------------------------------------
// led_animation_button_sequencer_top
// button driven led animation sequencer with brightness and sleep control
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_func, req_button_pressed
//   rsp      out        rsp_valid/rsp_stall  rsp_led_bits, rsp_nose_on, rsp_duty,
//                                            rsp_full_on, rsp_sleeping
//   csr      in         csr_write            csr_index, csr_data
//
// one item per cycle sustained while rsp is not stalled; req passes the input register, then the result register
// the input register feeds the state logic and the result register directly
// reset sets all state but the payload registers at once, no clearing pass
// a stalled rsp holds one more item in the input register, then req stalls
// ----------------------------------------------------------------------------
`include "led_animation_button_sequencer_top_defines.svh"

module led_animation_button_sequencer_top
   import lab_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_func,
   input  logic       req_button_pressed,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_led_bits,
   output logic       rsp_nose_on,
   output logic [7:0] rsp_duty,
   output logic       rsp_full_on,
   output logic       rsp_sleeping,
   input  logic       csr_write,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);

   cfg_type    cfg;
   result_type result;
   result_type rsp_ff;
   logic       in_valid_ff, in_valid_in;
   logic       in_func_ff, in_pressed_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_ready;
   logic       fire;

   lab_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   lab_core u_core (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .fire           (fire),
      .func           (in_func_ff),
      .button_pressed (in_pressed_ff),
      .result         (result)
   );

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;

   always_comb begin
      in_valid_in = req_stall ? in_valid_ff : req_valid;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_func_ff    <= req_func;
         in_pressed_ff <= req_button_pressed;
      end
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_led_bits = rsp_ff.led_bits;
   assign rsp_nose_on  = rsp_ff.nose_on;
   assign rsp_duty     = rsp_ff.duty;
   assign rsp_full_on  = rsp_ff.full_on;
   assign rsp_sleeping = rsp_ff.sleeping;

   `LAB_ASSERT_IMPL(a_sleep_dark, rsp_valid_ff && rsp_ff.sleeping, rsp_ff.duty == 8'd0 && !rsp_ff.full_on && rsp_ff.led_bits == 8'd0 && !rsp_ff.nose_on, "sleeping result not dark")
   `LAB_ASSERT_IMPL(a_one_led, rsp_valid_ff, $countones(rsp_ff.led_bits) <= 1, "more than one led set")
   `LAB_ASSERT_IMPL(a_fire_room, fire, !rsp_valid_ff || !rsp_stall, "result overwritten while stalled")
   `LAB_ASSERT_NEXT(a_hold_item, in_valid_ff && !fire, in_valid_ff && $stable(in_func_ff) && $stable(in_pressed_ff), "held item lost")
   `LAB_ASSERT_NEXT(a_fire_shows, fire, rsp_valid_ff, "fired item gave no result")

endmodule
